// ----- hw/rtl/pfxeval_pkg.sv -----
// Shared types and constants for the postfix expression evaluator.
// No dependencies; every module of the block imports this package.
`default_nettype none

package pfxeval_pkg;

    // character codes
    localparam logic [7:0] SYM_DIGIT_LO = 8'h31;
    localparam logic [7:0] SYM_DIGIT_HI = 8'h39;
    localparam logic [7:0] SYM_MUL      = 8'h2A;
    localparam logic [7:0] SYM_ADD      = 8'h2B;
    localparam logic [7:0] SYM_SUB      = 8'h2D;
    localparam logic [7:0] SYM_ZERO     = 8'h30;

    localparam logic [31:0] EMPTY_VALUE = 32'hFFFF_FFFF;

    // decoded-op queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_NOP  = 3'd0,
        OP_PUSH = 3'd1,
        OP_MUL  = 3'd2,
        OP_ADD  = 3'd3,
        OP_SUB  = 3'd4
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [3:0] digit;
        logic       last;
    } op_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pfxeval_sym_if.sv -----
// Input channel: one expression character per request.
// No dependencies.
`default_nettype none

interface pfxeval_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       end_of_expr;

    modport source (output valid, output symbol, output end_of_expr, input ready);
    modport sink   (input valid, input symbol, input end_of_expr, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pfxeval_res_if.sv -----
// Result channel: expression value and dropped-push flag.
// No dependencies.
`default_nettype none

interface pfxeval_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               push_dropped;

    modport source (output valid, output value, output push_dropped, input ready);
    modport sink   (input valid, input value, input push_dropped, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pfxeval_front.sv -----
// Front end: accepts characters and decodes them into stack ops.
// Depends on pfxeval_pkg and pfxeval_sym_if.
`default_nettype none

module pfxeval_front (
    pfxeval_sym_if.sink           sym,
    input  logic                  q_full,
    output logic                  q_push,
    output pfxeval_pkg::op_item_t q_item
);
    import pfxeval_pkg::*;

    logic [7:0] diff;

    assign diff = sym.symbol - SYM_ZERO;

    always_comb
    begin
        q_item.kind  = OP_NOP;
        q_item.digit = diff[3:0];
        q_item.last  = sym.end_of_expr;
        if (sym.symbol >= SYM_DIGIT_LO && sym.symbol <= SYM_DIGIT_HI)
        begin
            q_item.kind = OP_PUSH;
        end
        else if (sym.symbol == SYM_MUL)
        begin
            q_item.kind = OP_MUL;
        end
        else if (sym.symbol == SYM_ADD)
        begin
            q_item.kind = OP_ADD;
        end
        else if (sym.symbol == SYM_SUB)
        begin
            q_item.kind = OP_SUB;
        end
    end

    assign sym.ready = !q_full;
    // ignored characters need no back-end slot unless they close an expression
    assign q_push = sym.valid && !q_full && (q_item.kind != OP_NOP || q_item.last);

endmodule

`default_nettype wire

// ----- hw/rtl/pfxeval_queue.sv -----
// Short FIFO of decoded ops between the front and back ends.
// Depends on pfxeval_pkg.
`default_nettype none

module pfxeval_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pfxeval_pkg::op_item_t push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output pfxeval_pkg::op_item_t head
);
    import pfxeval_pkg::*;

    op_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pfxeval_back.sv -----
// Back end: operand stack (top cached in a register, rest in a memory),
// ALU and result register. Depends on pfxeval_pkg and pfxeval_res_if.
`default_nettype none

module pfxeval_back #(
    parameter int STACK_DEPTH = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  pfxeval_pkg::op_item_t head,
    output logic                  head_pop,
    pfxeval_res_if.source         res
);
    import pfxeval_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_EXEC = 2'b01,
        ST_OPER = 2'b10
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           ovf_reg;
    logic           ovf_next;
    logic [31:0]    top_reg;
    logic [31:0]    top_next;
    logic [31:0]    left_reg;
    logic [31:0]    stack_mem [STACK_DEPTH];

    logic           out_valid_reg;
    logic [31:0]    out_value_reg;
    logic           out_drop_reg;

    logic           is_oper;
    logic           out_free;
    logic           need_read;
    logic           done;
    logic           wr_en;
    logic [CW-1:0]  cnt_m1;
    logic [CW-1:0]  cnt_m2;
    logic [31:0]    right_op;
    logic [31:0]    left_op;
    logic [31:0]    alu;

    assign is_oper   = (head.kind == OP_MUL) || (head.kind == OP_ADD) || (head.kind == OP_SUB);
    assign out_free  = !out_valid_reg || res.ready;
    assign need_read = head_valid && is_oper && (state_reg == ST_EXEC);
    assign done      = head_valid && ((state_reg == ST_OPER) || !is_oper)
                       && (!head.last || out_free);
    assign head_pop  = done;

    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_m2   = count_reg - CW'(2);
    // a missing operand reads as -1
    assign right_op = (count_reg != '0) ? top_reg : EMPTY_VALUE;
    assign left_op  = (count_reg > CW'(1)) ? left_reg : EMPTY_VALUE;

    always_comb
    begin
        case (head.kind)
            OP_MUL:  alu = left_op * right_op;
            OP_ADD:  alu = left_op + right_op;
            OP_SUB:  alu = left_op - right_op;
            default: alu = right_op;
        endcase
    end

    always_comb
    begin
        top_next   = top_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        wr_en      = 1'b0;
        case (head.kind)
            OP_PUSH:
            begin
                if (count_reg == CW'(STACK_DEPTH))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    top_next   = {28'd0, head.digit};
                    count_next = count_reg + CW'(1);
                    wr_en      = (count_reg != '0);
                end
            end
            OP_MUL, OP_ADD, OP_SUB:
            begin
                // two pops and a push never overflow; entries below stay put
                top_next   = alu;
                count_next = (count_reg > CW'(1)) ? cnt_m1 : CW'(1);
            end
            default:
            begin
                top_next = top_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        if (need_read)
        begin
            state_next = ST_OPER;
        end
        else if (done)
        begin
            state_next = ST_EXEC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_EXEC;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
            begin
                count_reg <= head.last ? '0 : count_next;
                ovf_reg   <= head.last ? 1'b0 : ovf_next;
            end
            if (done && head.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            top_reg <= top_next;
        end
        if (done && head.last)
        begin
            out_value_reg <= (count_next != '0) ? top_next : EMPTY_VALUE;
            out_drop_reg  <= ovf_next;
        end
    end

    // stack memory: entries below the cached top, one write and one read port
    always_ff @(posedge clk)
    begin
        if (done && wr_en)
        begin
            stack_mem[cnt_m1[AW-1:0]] <= top_reg;
        end
        if (need_read && (count_reg > CW'(1)))
        begin
            left_reg <= stack_mem[cnt_m2[AW-1:0]];
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.value        = out_value_reg;
    assign res.push_dropped = out_drop_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/postfix_expression_evaluator_unit.sv -----
// Top level of the postfix expression evaluator.
// Depends on pfxeval_pkg, the channel interfaces, front, queue and back.
//
// Use: characters arrive on sym (valid/ready, symbol plus end_of_expr).
// Digits 1-9 push, '*' '+' '-' pop right then left and push the result,
// anything else is ignored. On a request with end_of_expr set, one result
// leaves on res: the top of the stack (-1 when empty) and a flag set when a
// push was dropped on a full stack; stack and flag then clear.
// With the queue empty, a closing digit or ignored character goes through the
// queue entry and then the result register; a closing operator also passes ST_OPER.
// Digits and other characters execute in ST_EXEC; an operator adds ST_OPER, which
// waits on the registered read of the stack memory (left operand) while the top
// operand sits in a register; the next op waits until the operator completes.
// A four-entry queue separates decode from execution, so sym keeps taking
// requests while the back end works or the result waits.
// Reset (rst_n, async): empty stack, flag clear, no result pending; the
// stack memory is not cleared and needs no sweep.
// When res stalls, the result holds and the back end stops only on the next
// closing request; the queue fills and then sym.ready drops.
`default_nettype none

module postfix_expression_evaluator_unit #(
    parameter int STACK_DEPTH = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    pfxeval_sym_if.sink   sym,
    pfxeval_res_if.source res
);
    import pfxeval_pkg::*;

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     head_valid;
    op_item_t q_item;
    op_item_t head;

    pfxeval_front u_front (
        .sym    (sym),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_item)
    );

    pfxeval_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head       (head)
    );

    pfxeval_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (q_pop),
        .res        (res)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/pfxeval_checker.sv -----
// Port-level checks for the postfix evaluator, bound to the top level.
// Depends on pfxeval_pkg.
`default_nettype none

module pfxeval_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        sym_valid,
    input logic        sym_ready,
    input logic        sym_end,
    input logic        res_valid,
    input logic        res_ready,
    input logic [31:0] res_value,
    input logic        res_dropped
);
    import pfxeval_pkg::*;

    // closing requests accepted but not yet delivered
    logic [7:0] pending_reg;
    logic       in_last;
    logic       out_take;

    assign in_last  = sym_valid && sym_ready && sym_end;
    assign out_take = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {7'd0, in_last} - {7'd0, out_take};
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_value) && $stable(res_dropped))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pending_reg != 8'd0)
        else $error("result without a closing request");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 8'(QUEUE_DEPTH + 1))
        else $error("more closing requests in flight than the block can hold");

endmodule

bind postfix_expression_evaluator_unit pfxeval_checker u_pfxeval_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .sym_valid   (sym.valid),
    .sym_ready   (sym.ready),
    .sym_end     (sym.end_of_expr),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_value   (res.value),
    .res_dropped (res.push_dropped)
);

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for postfix_expression_evaluator_unit.
// Uses pfxeval_pkg and the sym/res channel interfaces; a stack model predicts each
// result, and directed plus random expressions run under random stalls on both sides.

module testbench;
    import pfxeval_pkg::*;

    localparam int STACK_DEPTH = 128;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 5000;

    typedef struct {
        logic signed [31:0] value;
        logic               dropped;
    } expr_result_t;

    logic clk = 1'b0;
    logic rst_n;

    always #5 clk = ~clk;

    pfxeval_sym_if sym_ch ();
    pfxeval_res_if res_ch ();

    postfix_expression_evaluator_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .sym  (sym_ch),
        .res  (res_ch)
    );

    // stack model
    logic [31:0]  model_stack [STACK_DEPTH];
    int unsigned  model_depth   = 0;
    logic         model_dropped = 1'b0;

    expr_result_t due_results [$];
    logic [7:0]   expr_chars [$];

    int unsigned error_count     = 0;
    int unsigned ops_sent        = 0;
    int unsigned holds_requested = 0;
    int unsigned holds_served    = 0;
    bit          steady_flow     = 1'b0;

    function automatic op_kind_t classify_symbol(input logic [7:0] s);
        if (s >= SYM_DIGIT_LO && s <= SYM_DIGIT_HI)
            return OP_PUSH;
        if (s == SYM_MUL)
            return OP_MUL;
        if (s == SYM_ADD)
            return OP_ADD;
        if (s == SYM_SUB)
            return OP_SUB;
        return OP_NOP;
    endfunction

    function automatic void model_push(input logic [31:0] v);
        if (model_depth >= STACK_DEPTH)
            model_dropped = 1'b1;
        else
        begin
            model_stack[model_depth] = v;
            model_depth++;
        end
    endfunction

    function automatic logic [31:0] model_pop();
        if (model_depth == 0)
            return EMPTY_VALUE;
        model_depth--;
        return model_stack[model_depth];
    endfunction

    // apply one accepted request to the model; a closing request queues its result
    function automatic void advance_stack_model(input logic [7:0] s, input logic last);
        op_kind_t     kind;
        logic [31:0]  rhs;
        logic [31:0]  lhs;
        logic [31:0]  r;
        expr_result_t outcome;
        kind = classify_symbol(s);
        if (kind == OP_PUSH)
            model_push(32'(s - SYM_ZERO));
        else if (kind != OP_NOP)
        begin
            rhs = model_pop();
            lhs = model_pop();
            if (kind == OP_MUL)
                r = lhs * rhs;
            else if (kind == OP_ADD)
                r = lhs + rhs;
            else
                r = lhs - rhs;
            model_push(r);
        end
        if (last)
        begin
            outcome.value   = (model_depth == 0) ? EMPTY_VALUE : model_stack[model_depth - 1];
            outcome.dropped = model_dropped;
            due_results.push_back(outcome);
            model_depth   = 0;
            model_dropped = 1'b0;
        end
    endfunction

    // mostly back-to-back, some short gaps, a few long ones; none during steady flow
    function automatic int unsigned idle_gap();
        int unsigned pick;
        if (steady_flow)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] random_digit();
        return SYM_DIGIT_LO + 8'($urandom_range(0, 8));
    endfunction

    function automatic logic [7:0] random_ignored();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (classify_symbol(b) != OP_NOP);
        return b;
    endfunction

    function automatic logic [7:0] random_operator();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return SYM_MUL;
        if (pick < 7)
            return SYM_ADD;
        return SYM_SUB;
    endfunction

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_symbol(input logic [7:0] s, input logic last);
        int unsigned gap;
        gap = idle_gap();
        if (gap != 0)
        begin
            sym_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sym_ch.valid       <= 1'b1;
        sym_ch.symbol      <= s;
        sym_ch.end_of_expr <= last;
        do
            @(posedge clk);
        while (!sym_ch.ready);
        advance_stack_model(s, last);
        if (classify_symbol(s) != OP_NOP)
            ops_sent++;
    endtask

    task automatic send_chars();
        foreach (expr_chars[i])
            send_symbol(expr_chars[i], i == expr_chars.size() - 1);
    endtask

    task automatic wait_results_drained();
        sym_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    // valid postfix expression with random content, ignored bytes sprinkled in
    task automatic build_wellformed(input int unsigned max_operands);
        int unsigned operands;
        int unsigned pushed;
        int unsigned depth;
        operands = $urandom_range(1, max_operands);
        pushed   = 0;
        depth    = 0;
        expr_chars.delete();
        while (pushed < operands || depth > 1)
        begin
            if (depth >= 2 && (pushed == operands || $urandom_range(0, 2) == 0))
            begin
                expr_chars.push_back(random_operator());
                depth--;
            end
            else
            begin
                expr_chars.push_back(random_digit());
                depth++;
                pushed++;
            end
            if ($urandom_range(0, 11) == 0)
                expr_chars.push_back(random_ignored());
        end
    endtask

    // operators and digits in any order, so pops often hit an empty stack
    task automatic build_broken();
        int unsigned len;
        int unsigned pick;
        len = $urandom_range(1, 10);
        expr_chars.delete();
        repeat (len)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                expr_chars.push_back(random_digit());
            else if (pick < 9)
                expr_chars.push_back(random_operator());
            else
                expr_chars.push_back(random_ignored());
        end
    endtask

    task automatic build_noise();
        int unsigned len;
        len = $urandom_range(1, 6);
        expr_chars.delete();
        repeat (len)
            expr_chars.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic test_directed_cases();
        send_symbol(SYM_ZERO + 8'd5, 1'b1);
        // empty expression reads -1
        send_symbol(8'h00, 1'b1);
        send_symbol(8'hFF, 1'b0);
        send_symbol(SYM_ZERO, 1'b0);
        send_symbol(SYM_DIGIT_HI, 1'b0);
        send_symbol(SYM_DIGIT_LO, 1'b0);
        send_symbol(SYM_SUB, 1'b1);
        // both operands missing: -1 + -1
        send_symbol(SYM_ADD, 1'b1);
        // left operand missing
        send_symbol(SYM_ZERO + 8'd7, 1'b0);
        send_symbol(SYM_MUL, 1'b1);
        send_symbol(SYM_ZERO + 8'd3, 1'b0);
        send_symbol(SYM_ZERO + 8'd4, 1'b0);
        send_symbol(SYM_MUL, 1'b1);
        send_symbol(SYM_ZERO + 8'd2, 1'b0);
        send_symbol(SYM_ZERO + 8'd8, 1'b0);
        send_symbol(SYM_ADD, 1'b0);
        // ignored character closes the expression
        send_symbol(8'h80, 1'b1);
        send_symbol(SYM_SUB, 1'b1);
    endtask

    task automatic test_stack_limits();
        // exactly full, nothing dropped
        for (int i = 0; i < STACK_DEPTH; i++)
            send_symbol(random_digit(), i == STACK_DEPTH - 1);
        // overfill, then free one slot, refill it and push once more onto the full stack
        for (int i = 0; i < STACK_DEPTH + 2; i++)
            send_symbol(random_digit(), 1'b0);
        send_symbol(SYM_ADD, 1'b0);
        send_symbol(random_digit(), 1'b0);
        send_symbol(SYM_DIGIT_HI, 1'b1);
        // flag must be clear again
        send_symbol(SYM_DIGIT_LO, 1'b1);
    endtask

    task automatic test_wrap_arithmetic();
        send_symbol(SYM_DIGIT_HI, 1'b0);
        send_symbol(SYM_DIGIT_HI, 1'b0);
        send_symbol(SYM_MUL, 1'b0);
        repeat (12)
        begin
            send_symbol(SYM_DIGIT_HI, 1'b0);
            send_symbol(SYM_MUL, 1'b0);
        end
        send_symbol(SYM_DIGIT_HI, 1'b0);
        send_symbol(SYM_ADD, 1'b1);
        // small minus huge
        send_symbol(SYM_DIGIT_LO, 1'b0);
        send_symbol(SYM_DIGIT_HI, 1'b0);
        repeat (10)
        begin
            send_symbol(SYM_DIGIT_HI, 1'b0);
            send_symbol(SYM_MUL, 1'b0);
        end
        send_symbol(SYM_SUB, 1'b1);
    endtask

    task automatic test_random_expressions(input int unsigned op_target);
        int unsigned start;
        int unsigned pick;
        start = ops_sent;
        while (ops_sent - start < op_target)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                build_wellformed(($urandom_range(0, 9) == 0) ? 40 : 6);
            else if (pick < 17)
                build_broken();
            else
                build_noise();
            send_chars();
        end
    endtask

    task automatic test_backpressure();
        holds_requested++;
        repeat (15)
        begin
            build_wellformed(4);
            send_chars();
        end
    endtask

    task automatic test_steady_burst();
        steady_flow = 1'b1;
        test_random_expressions(50);
        steady_flow = 1'b0;
    endtask

    // result ready: random high/low stretches, plus long hold-offs on request
    int unsigned stall_left = 0;
    int unsigned ready_left = 0;

    always @(posedge clk)
    begin : drive_result_ready
        int unsigned gap;
        if (holds_served != holds_requested)
        begin
            holds_served = holds_requested;
            stall_left   = HOLD_CYCLES;
            res_ch.ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end
        else if (ready_left != 0)
        begin
            ready_left--;
            res_ch.ready <= 1'b1;
        end
        else
        begin
            gap = idle_gap();
            if (gap == 0)
            begin
                res_ch.ready <= 1'b1;
                ready_left = $urandom_range(0, 15);
            end
            else
            begin
                res_ch.ready <= 1'b0;
                stall_left = gap - 1;
            end
        end
    end

    always @(posedge clk)
    begin : check_result
        expr_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (due_results.size() == 0)
            begin
                error_count++;
                $display("%0t unexpected result: expected none, got value %0d dropped %0b",
                         $time, res_ch.value, res_ch.push_dropped);
            end
            else
            begin
                want = due_results.pop_front();
                if (res_ch.value !== want.value)
                begin
                    error_count++;
                    $display("%0t value mismatch: expected %0d, got %0d",
                             $time, want.value, res_ch.value);
                end
                if (res_ch.push_dropped !== want.dropped)
                begin
                    error_count++;
                    $display("%0t push_dropped mismatch: expected %0b, got %0b",
                             $time, want.dropped, res_ch.push_dropped);
                end
            end
        end
    end

    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((sym_ch.valid && sym_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        sym_ch.valid       = 1'b0;
        sym_ch.symbol      = 8'h00;
        sym_ch.end_of_expr = 1'b0;
        res_ch.ready       = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        wait_results_drained();
        test_stack_limits();
        test_wrap_arithmetic();
        test_random_expressions(110);
        test_backpressure();
        wait_results_drained();
        test_steady_burst();
        test_random_expressions(110);

        wait_results_drained();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- postfix_expression_evaluator_unit.f -----
hw/rtl/pfxeval_pkg.sv
hw/rtl/pfxeval_sym_if.sv
hw/rtl/pfxeval_res_if.sv
hw/rtl/pfxeval_front.sv
hw/rtl/pfxeval_queue.sv
hw/rtl/pfxeval_back.sv
hw/rtl/postfix_expression_evaluator_unit.sv
hw/rtl/pfxeval_checker.sv
tb/testbench.sv
